@@ hdl/bitmap_page_allocator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit_assert.svh
// Assertion macros shared by the page allocator modules. Each macro expects
// clk and rst in the scope of its use.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpa assertion failed");

// next-cycle implication
`define BPA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpa assertion failed");

`endif

@@ hdl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, codes and helper functions of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // request operation
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] RES_DONE    = 2'd0;
  localparam logic [1:0] RES_OOM     = 2'd1;
  localparam logic [1:0] RES_IGNORED = 2'd2;

  // register map
  localparam int         APB_AW           = 3;
  localparam logic [0:0] REG_FIRST_FREE   = 1'b0;
  localparam logic [15:0] FIRST_FREE_RESET = 16'd512;

  localparam int PAGE_ADDR_W = 28;
  localparam int COUNT_OUT_W = 17;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_SCAN,
    ST_ALLOC_WR,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_RC_START,
    ST_RC_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;       // clearing pass, one word per cycle
    logic accept;      // latch request
    logic scan_start;  // load scan address with first allocatable word
    logic scan_run;    // keep issuing scan reads
    logic scan;        // alloc scan: capture first word with a free bit
    logic rc_clr;      // zero used counter
    logic rc_acc;      // add popcount of scanned word
    logic set_oom;
    logic set_ign;
    logic alloc_wr;    // set the found bit
    logic free_rd;     // read word of page to free
    logic free_wr;     // clear page bit if set
    logic out_load;    // load result register
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic empty;       // no allocatable page
    logic found;
    logic scan_end;
    logic free_ok;
    logic out_free;
  } dp_stat_t;

  function automatic logic [6:0] pop64(input logic [63:0] v);
    logic [1:0] s1 [32];
    logic [2:0] s2 [16];
    logic [3:0] s3 [8];
    logic [4:0] s4 [4];
    logic [5:0] s5 [2];
    for (int i = 0; i < 32; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    return {1'b0, s5[0]} + {1'b0, s5[1]};
  endfunction

  // index of the set bit of a one-hot word
  function automatic logic [5:0] onehot_idx(input logic [63:0] oh);
    logic [5:0] r;
    r = '0;
    for (int k = 0; k < 64; k++) begin
      if (oh[k]) r = r | 6'(k);
    end
    return r;
  endfunction

endpackage

@@ hdl/bitmap_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// First-fit page allocator over a used-page bitmap, with an APB register for
// the first allocatable page.
// ----------------------------------------------------------------------------
//  port group   dir  handshake            payload
//  request      in   in_valid/in_ready    cmd, address
//  result       out  out_valid/out_ready  status, page_address, used_count, free_count
//  config       in   psel/penable/pwrite  paddr, pwdata, prdata
//
//  Alloc: scans bitmap words from the word of first_free_page, one word per
//  cycle through the memory read port, then sets the first free bit found.
//  Free: read and write back of one word, skipped when the page is outside
//  the allocatable range.
//  After reset a clearing pass zeros the bitmap word by word; no request is
//  taken until it ends.
//  A write of first_free_page recounts used pages, with requests held off.
//  A stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit #(
  parameter int PAGE_COUNT = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpa_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [63:0]                 address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [27:0]                 page_address,
  output logic [16:0]                 used_count,
  output logic [16:0]                 free_count
);

  logic [15:0]       first_free_page;
  logic              cfg_wr;
  logic              reg_hit;
  bpa_pkg::dp_cmd_t  ctl;
  bpa_pkg::dp_stat_t stat;

  assign pready  = 1'b1;
  assign reg_hit = paddr[bpa_pkg::APB_AW-1:2] == bpa_pkg::REG_FIRST_FREE;
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? {16'd0, first_free_page} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_free_page <= bpa_pkg::FIRST_FREE_RESET;
    end else if (cfg_wr) begin
      first_free_page <= pwdata[15:0];
    end
  end

  bpa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_is_free (cmd == bpa_pkg::CMD_FREE),
    .cfg_wr     (cfg_wr),
    .stat       (stat),
    .ctl        (ctl)
  );

  bpa_datapath #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .stat             (stat),
    .ffp              (first_free_page),
    .in_address       (address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (status),
    .out_page_address (page_address),
    .out_used_count   (used_count),
    .out_free_count   (free_count)
  );

endmodule

@@ hdl/bpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the page allocator: clearing pass, alloc scan, free update,
// recount after a register write, result handoff.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_unit_assert.svh"

module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_is_free,
  input  logic              cfg_wr,
  input  bpa_pkg::dp_stat_t stat,
  output bpa_pkg::dp_cmd_t  ctl
);

  bpa_pkg::state_t state, state_next;
  logic            accept;

  assign in_ready = (state == bpa_pkg::ST_IDLE) && !cfg_wr;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bpa_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = bpa_pkg::ST_IDLE;
      end
      bpa_pkg::ST_IDLE: begin
        if (cfg_wr) state_next = bpa_pkg::ST_RC_START;
        else if (accept) state_next = in_is_free ? bpa_pkg::ST_FREE_RD : bpa_pkg::ST_ALLOC;
      end
      bpa_pkg::ST_ALLOC: begin
        state_next = stat.empty ? bpa_pkg::ST_DONE : bpa_pkg::ST_SCAN;
      end
      bpa_pkg::ST_SCAN: begin
        if (stat.found) state_next = bpa_pkg::ST_ALLOC_WR;
        else if (stat.scan_end) state_next = bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_ALLOC_WR: state_next = bpa_pkg::ST_DONE;
      bpa_pkg::ST_FREE_RD: begin
        state_next = stat.free_ok ? bpa_pkg::ST_FREE_WR : bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_FREE_WR: state_next = bpa_pkg::ST_DONE;
      bpa_pkg::ST_RC_START: begin
        if (cfg_wr) state_next = bpa_pkg::ST_RC_START;
        else if (stat.empty) state_next = bpa_pkg::ST_IDLE;
        else state_next = bpa_pkg::ST_RC_SCAN;
      end
      bpa_pkg::ST_RC_SCAN: begin
        if (cfg_wr) state_next = bpa_pkg::ST_RC_START;
        else if (stat.scan_end) state_next = bpa_pkg::ST_IDLE;
      end
      bpa_pkg::ST_DONE: begin
        if (stat.out_free) state_next = bpa_pkg::ST_IDLE;
      end
      default: state_next = bpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      bpa_pkg::ST_CLEAR: ctl.clear = 1'b1;
      bpa_pkg::ST_IDLE:  ctl.accept = accept;
      bpa_pkg::ST_ALLOC: begin
        ctl.set_oom    = stat.empty;
        ctl.scan_start = !stat.empty;
      end
      bpa_pkg::ST_SCAN: begin
        ctl.scan     = 1'b1;
        ctl.scan_run = !stat.found;
        ctl.set_oom  = !stat.found && stat.scan_end;
      end
      bpa_pkg::ST_ALLOC_WR: ctl.alloc_wr = 1'b1;
      bpa_pkg::ST_FREE_RD: begin
        ctl.set_ign = !stat.free_ok;
        ctl.free_rd = stat.free_ok;
      end
      bpa_pkg::ST_FREE_WR: ctl.free_wr = 1'b1;
      bpa_pkg::ST_RC_START: begin
        ctl.rc_clr     = 1'b1;
        ctl.scan_start = !stat.empty && !cfg_wr;
      end
      bpa_pkg::ST_RC_SCAN: begin
        ctl.rc_acc   = !cfg_wr;
        ctl.scan_run = !cfg_wr;
      end
      bpa_pkg::ST_DONE: ctl.out_load = stat.out_free;
      default: ctl = '0;
    endcase
  end

  `BPA_ASSERT_NXT(a_dispatch, accept,
                  state == bpa_pkg::ST_ALLOC || state == bpa_pkg::ST_FREE_RD)

endmodule

@@ hdl/bpa_datapath.sv @@
// ----------------------------------------------------------------------------
// bpa_datapath
// Used-page bitmap memory, scan address and read pipeline, used counter,
// request and result registers.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_unit_assert.svh"

module bpa_datapath #(
  parameter int PAGE_COUNT = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  bpa_pkg::dp_cmd_t  ctl,
  output bpa_pkg::dp_stat_t stat,
  input  logic [15:0]       ffp,
  input  logic [63:0]       in_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [27:0]       out_page_address,
  output logic [16:0]       out_used_count,
  output logic [16:0]       out_free_count
);

  localparam int WORDS = (PAGE_COUNT + 63) / 64;
  localparam int WAW   = $clog2(WORDS);
  localparam int PIW   = WAW + 6;
  localparam int CW    = $clog2(PAGE_COUNT + 1);
  localparam int OFFW  = $clog2(PAGE_BYTES);
  localparam int PGW   = 64 - OFFW;
  localparam int SW    = (WAW > 10) ? WAW : 10;
  localparam int AW    = (PIW + OFFW > bpa_pkg::PAGE_ADDR_W) ? PIW + OFFW
                                                             : bpa_pkg::PAGE_ADDR_W;
  localparam int UXW   = (CW > bpa_pkg::COUNT_OUT_W) ? CW : bpa_pkg::COUNT_OUT_W;
  localparam int LAST_BITS = PAGE_COUNT - (WORDS - 1) * 64;
  localparam logic [WAW-1:0] LAST_W = WAW'(WORDS - 1);
  localparam logic [63:0] TAIL_MASK =
    (LAST_BITS == 64) ? 64'd0 : ~((64'd1 << LAST_BITS) - 64'd1);
  localparam logic [CW-1:0] PAGES = CW'(PAGE_COUNT);

  logic [63:0]     mem [WORDS];
  logic [63:0]     rdata;
  logic            rd_en, wr_en;
  logic [WAW-1:0]  rd_addr, wr_addr;
  logic [63:0]     wr_data;

  logic [WAW-1:0]  iaddr;
  logic            issuing;
  logic            scan_rd;
  logic            rvalid;
  logic [WAW-1:0]  rword;

  logic [63:0]     req_address;
  logic [1:0]      res_status;
  logic [27:0]     res_addr;
  logic [CW-1:0]   used;

  logic [WAW-1:0]  hit_word;
  logic [5:0]      hit_bit;
  logic [63:0]     hit_data;

  logic            empty;
  logic [SW-1:0]   start_x;
  logic [WAW-1:0]  start_word;
  logic [63:0]     below_mask;
  logic [63:0]     busy_bits;
  logic [63:0]     zero_bits;
  logic [63:0]     first_zero;
  logic            word_has_free;

  logic [PGW-1:0]  free_pg;
  logic [PIW-1:0]  free_page;
  logic [WAW-1:0]  free_word;
  logic [5:0]      free_bit;
  logic            free_set;

  logic [PIW-1:0]  hit_page;
  logic [AW-1:0]   hit_addr_x;
  logic [CW-1:0]   total;
  logic [CW-1:0]   free_cnt;
  logic [UXW-1:0]  used_x, free_x;

  assign empty      = 32'(ffp) >= 32'(PAGE_COUNT);
  assign start_x    = SW'(ffp[15:6]);
  assign start_word = start_x[WAW-1:0];

  // pages below the first allocatable one, in its own word
  assign below_mask = (rword == start_word) ? ((64'd1 << ffp[5:0]) - 64'd1) : 64'd0;
  assign busy_bits  = rdata | below_mask | ((rword == LAST_W) ? TAIL_MASK : 64'd0);
  assign zero_bits  = ~busy_bits;
  assign first_zero = zero_bits & (~zero_bits + 64'd1);
  assign word_has_free = zero_bits != 64'd0;

  assign free_pg   = req_address[63:OFFW];
  assign free_page = free_pg[PIW-1:0];
  assign free_word = free_page[PIW-1:6];
  assign free_bit  = free_page[5:0];
  assign free_set  = rdata[free_bit];

  assign scan_rd = issuing && ctl.scan_run;

  // memory ports
  assign rd_en   = scan_rd || ctl.free_rd;
  assign rd_addr = ctl.free_rd ? free_word : iaddr;
  assign wr_en   = ctl.clear || ctl.alloc_wr || (ctl.free_wr && free_set);

  always_comb begin
    if (ctl.clear) begin
      wr_addr = iaddr;
      wr_data = 64'd0;
    end else if (ctl.alloc_wr) begin
      wr_addr = hit_word;
      wr_data = hit_data | (64'd1 << hit_bit);
    end else begin
      wr_addr = free_word;
      wr_data = rdata & ~(64'd1 << free_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // scan address and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      iaddr   <= '0;
      issuing <= 1'b0;
      rvalid  <= 1'b0;
    end else begin
      rvalid <= scan_rd;
      if (ctl.scan_start) begin
        iaddr   <= start_word;
        issuing <= 1'b1;
      end else if (ctl.clear) begin
        iaddr <= iaddr + WAW'(1);
      end else if (scan_rd) begin
        if (iaddr == LAST_W) issuing <= 1'b0;
        else iaddr <= iaddr + WAW'(1);
      end else begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rword <= iaddr;
    if (ctl.accept) req_address <= in_address;
    if (ctl.scan && stat.found) begin
      hit_word <= rword;
      hit_bit  <= bpa_pkg::onehot_idx(first_zero);
      hit_data <= rdata;
    end
  end

  assign hit_page   = {hit_word, hit_bit};
  assign hit_addr_x = AW'({hit_page, {OFFW{1'b0}}});

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      res_status <= bpa_pkg::RES_DONE;
      res_addr   <= '0;
    end else if (ctl.set_oom) begin
      res_status <= bpa_pkg::RES_OOM;
    end else if (ctl.set_ign) begin
      res_status <= bpa_pkg::RES_IGNORED;
    end else if (ctl.alloc_wr) begin
      res_addr <= hit_addr_x[27:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ctl.rc_clr) begin
      used <= '0;
    end else if (ctl.rc_acc && rvalid) begin
      used <= used + CW'(bpa_pkg::pop64(rdata & ~below_mask));
    end else if (ctl.alloc_wr) begin
      used <= used + CW'(1);
    end else if (ctl.free_wr && free_set && used != '0) begin
      used <= used - CW'(1);
    end
  end

  assign total    = empty ? '0 : PAGES - CW'(ffp);
  assign free_cnt = (total >= used) ? total - used : '0;
  assign used_x   = UXW'(used);
  assign free_x   = UXW'(free_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status       <= res_status;
      out_page_address <= res_addr;
      out_used_count   <= used_x[16:0];
      out_free_count   <= free_x[16:0];
    end
  end

  assign stat.clear_last = iaddr == LAST_W;
  assign stat.empty      = empty;
  assign stat.found      = rvalid && word_has_free;
  assign stat.scan_end   = rvalid && (rword == LAST_W);
  assign stat.free_ok    = (free_pg >= PGW'(ffp)) && (free_pg < PGW'(PAGE_COUNT));
  assign stat.out_free   = !out_valid || out_ready;

  `BPA_ASSERT_IMP(a_no_overwrite, ctl.out_load, !out_valid || out_ready)
  `BPA_ASSERT_IMP(a_alloc_bit_free, ctl.alloc_wr, !hit_data[hit_bit])
  `BPA_ASSERT_IMP(a_used_in_range, ctl.out_load, used <= total)

endmodule

@@ verif/bpa_checker.sv @@
// ----------------------------------------------------------------------------
// bpa_checker
// Watches the request, result and register ports of the page allocator. Keeps
// its own used-page bitmap and first-page setting, predicts each result and
// compares the results in order. Reports mismatches and open results.
// ----------------------------------------------------------------------------
module bpa_checker #(
  parameter int PAGE_COUNT = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [bpa_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       cmd,
  input  logic [63:0]                address,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [1:0]                 status,
  input  logic [27:0]                page_address,
  input  logic [16:0]                used_count,
  input  logic [16:0]                free_count,
  output int                         outstanding,
  output int                         mismatches
);

  localparam int WORDS = PAGE_COUNT / 64;
  localparam logic [bpa_pkg::APB_AW-1:0] FIRST_FREE_ADDR = {bpa_pkg::REG_FIRST_FREE, 2'b00};

  typedef struct packed {
    logic [1:0]  status;
    logic [27:0] page_address;
    logic [16:0] used;
    logic [16:0] free;
  } page_result_t;

  logic [63:0]  used_words [WORDS];
  logic [15:0]  first_page;
  int unsigned  used_cnt;
  page_result_t results_due [$];

  // used count over the allocatable range only
  function automatic void recount_used();
    used_cnt = 0;
    for (int p = first_page; p < PAGE_COUNT; p++) begin
      used_cnt += used_words[p / 64][p % 64];
    end
  endfunction

  function automatic page_result_t predict_page_op(input logic op, input logic [63:0] addr);
    page_result_t r;
    int           w;
    int           pg;
    int           total;
    logic [63:0]  word;
    logic [63:0]  idx;
    r = '0;
    if (op == bpa_pkg::CMD_ALLOC) begin
      pg = -1;
      w = first_page / 64;
      while (pg < 0 && w < WORDS) begin
        word = used_words[w];
        // pages below the first allocatable one count as taken
        if (w == first_page / 64) word = word | ((64'd1 << first_page[5:0]) - 64'd1);
        for (int b = 63; b >= 0; b--) begin
          if (!word[b]) pg = w * 64 + b;
        end
        w++;
      end
      if (pg >= 0) begin
        used_words[pg / 64][pg % 64] = 1'b1;
        used_cnt++;
        r.page_address = 28'(pg * PAGE_BYTES);
      end else begin
        r.status = bpa_pkg::RES_OOM;
      end
    end else begin
      idx = addr / PAGE_BYTES;
      if (idx >= first_page && idx < PAGE_COUNT) begin
        if (used_words[idx / 64][idx % 64]) begin
          used_words[idx / 64][idx % 64] = 1'b0;
          if (used_cnt > 0) used_cnt--;
        end
      end else begin
        r.status = bpa_pkg::RES_IGNORED;
      end
    end
    total = (first_page >= PAGE_COUNT) ? 0 : PAGE_COUNT - first_page;
    r.used = 17'(used_cnt);
    r.free = (total >= used_cnt) ? 17'(total - used_cnt) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    page_result_t got;
    if (rst) begin
      for (int w = 0; w < WORDS; w++) used_words[w] = '0;
      first_page = bpa_pkg::FIRST_FREE_RESET;
      used_cnt = 0;
      results_due.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {status, page_address, used_count, free_count};
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result status=%0d addr=%h used=%0d free=%0d",
                     $time, status, page_address, used_count, free_count);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: exp st=%0d a=%h u=%0d f=%0d, got st=%0d a=%h u=%0d f=%0d",
                       $time, want.status, want.page_address, want.used, want.free,
                       got.status, got.page_address, got.used, got.free);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == FIRST_FREE_ADDR) begin
        first_page = pwdata[15:0];
        recount_used();
      end
      if (in_valid && in_ready) results_due.push_back(predict_page_op(cmd, address));
      outstanding <= results_due.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench of the bitmap page allocator. Drives directed and random allocate
// and free requests under several first-page settings, with random idling on
// both sides, a long result stall and drain pauses; bpa_checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PAGE_SHIFT   = 12;
  localparam int PHASE_ITEMS  = 94;
  localparam logic [bpa_pkg::APB_AW-1:0] FIRST_FREE_ADDR = {bpa_pkg::REG_FIRST_FREE, 2'b00};

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [bpa_pkg::APB_AW-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_ready;
  logic                       cmd;
  logic [63:0]                address;
  logic                       out_valid;
  logic                       out_ready;
  logic [1:0]                 status;
  logic [27:0]                page_address;
  logic [16:0]                used_count;
  logic [16:0]                free_count;

  int          outstanding;
  int          mismatches;
  logic        calm;
  logic        hold_go;
  logic        held;
  int          n_alloc;
  int          n_free;
  int          n_settings;
  logic [15:0] first_now;
  int unsigned span;
  logic [15:0] phase_first [6];

  bitmap_page_allocator_unit u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .cmd, .address,
    .out_valid, .out_ready, .status, .page_address, .used_count, .free_count
  );

  bpa_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_ready, .cmd, .address,
    .out_valid, .out_ready, .status, .page_address, .used_count, .free_count,
    .outstanding, .mismatches
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  function automatic logic [63:0] page_addr(input int unsigned page);
    return (64'(page) << PAGE_SHIFT) | 64'($urandom_range(0, 4095));
  endfunction

  task automatic offer_request(input logic op, input logic [63:0] addr);
    while (!calm && $urandom_range(0, 99) < 10) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= op;
    address  <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == bpa_pkg::CMD_ALLOC) begin
      n_alloc++;
      span++;
    end else begin
      n_free++;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_first_free(input logic [15:0] value);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FIRST_FREE_ADDR;
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    first_now = value;
    span = 4;
    n_settings++;
  endtask

  // mostly allocs and frees near the live pages, some junk frees
  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      offer_request(bpa_pkg::CMD_ALLOC, {$urandom, $urandom});
    else if (r < 90)
      offer_request(bpa_pkg::CMD_FREE, page_addr(first_now + $urandom_range(0, span)));
    else if (r < 95 && first_now > 0)
      offer_request(bpa_pkg::CMD_FREE, page_addr($urandom_range(0, first_now - 1)));
    else
      offer_request(bpa_pkg::CMD_FREE, {$urandom, $urandom});
  endtask

  initial begin
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    cmd        = bpa_pkg::CMD_ALLOC;
    address    = '0;
    calm       = 1'b0;
    hold_go    = 1'b0;
    n_alloc    = 0;
    n_free     = 0;
    n_settings = 1;
    first_now  = bpa_pkg::FIRST_FREE_RESET;
    span       = 4;
    phase_first[0] = 16'($urandom_range(1, 4000));
    phase_first[1] = 16'd65472;
    phase_first[2] = 16'd0;
    phase_first[3] = 16'($urandom);
    phase_first[4] = 16'd65530;
    phase_first[5] = bpa_pkg::FIRST_FREE_RESET;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset setting: first allocations, double free, reserved and wild frees
    offer_request(bpa_pkg::CMD_ALLOC, '0);
    offer_request(bpa_pkg::CMD_ALLOC, '1);
    offer_request(bpa_pkg::CMD_FREE, page_addr(513));
    offer_request(bpa_pkg::CMD_FREE, page_addr(513));
    offer_request(bpa_pkg::CMD_FREE, page_addr(511));
    offer_request(bpa_pkg::CMD_FREE, '1);
    offer_request(bpa_pkg::CMD_FREE, 64'd65536 << PAGE_SHIFT);
    offer_request(bpa_pkg::CMD_FREE, page_addr(65535));
    offer_request(bpa_pkg::CMD_ALLOC, 64'h5555_aaaa_5555_aaaa);

    // everything allocatable, page zero included
    set_first_free(16'd0);
    offer_request(bpa_pkg::CMD_ALLOC, '0);
    offer_request(bpa_pkg::CMD_FREE, 64'hfff);
    offer_request(bpa_pkg::CMD_ALLOC, '0);
    offer_request(bpa_pkg::CMD_FREE, page_addr(512));

    // single allocatable page: runs out at once
    set_first_free(16'hffff);
    offer_request(bpa_pkg::CMD_ALLOC, '0);
    offer_request(bpa_pkg::CMD_ALLOC, '0);
    offer_request(bpa_pkg::CMD_FREE, 64'd65535 << PAGE_SHIFT);
    offer_request(bpa_pkg::CMD_ALLOC, '1);
    offer_request(bpa_pkg::CMD_FREE, '0);

    for (int ph = 0; ph < 6; ph++) begin
      set_first_free(phase_first[ph]);
      calm = (ph == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == 40) hold_go = 1'b1;
        random_request();
      end
    end
    calm = 1'b0;
    wait_idle();
    repeat (50) @(posedge clk);

    $display("Run covered %0d allocate and %0d free requests over %0d first-page settings",
             n_alloc, n_free, n_settings);
    $display("with reserved and wild frees, exhausted ranges and a %0d-cycle result stall",
             HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_ctrl.sv
hdl/bpa_datapath.sv
hdl/bitmap_page_allocator_unit.sv
verif/bpa_checker.sv
verif/tb.sv
